// ----- hdl/llk_pkg.sv -----
// Shared types and constants of the logistic log-likelihood block.
package llk_pkg;

  localparam int LLK_MAX_FEATURES = 64;
  localparam int LLK_CFG_W        = 7;
  localparam int LLK_IDX_W        = 6;
  localparam int LLK_VAL_W        = 16;
  localparam int LLK_LL_W         = 29;
  localparam int LLK_TOT_W        = 48;
  localparam int LLK_OUT_DEPTH    = 8;
  localparam int LLK_SP_W         = 21;
  localparam int LLK_SP_IDX_W     = 12;

  localparam logic LLK_KIND_COEF = 1'b0;
  localparam logic LLK_KIND_FEAT = 1'b1;

  typedef struct packed {
    logic                        kind;
    logic [LLK_IDX_W-1:0]        coeff_index;
    logic signed [LLK_VAL_W-1:0] value;
    logic                        label;
    logic                        first_obs;
  } llk_in_t;

  typedef struct packed {
    logic signed [LLK_LL_W-1:0]  obs_loglik;
    logic signed [LLK_TOT_W-1:0] total_loglik;
  } llk_out_t;

  typedef struct packed {
    logic valid;
    logic label;
    logic first_obs;
  } llk_obs_ctl_t;

  typedef struct packed {
    logic                       valid;
    logic                       first_obs;
    logic signed [LLK_LL_W-1:0] ll;
  } llk_ll_t;

endpackage

// ----- hdl/llk_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module llk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/llk_sp_rom.sv -----
// Softplus table in Q.16 over -16..16 in steps of 1/64, read as a registered pair.
module llk_sp_rom import llk_pkg::*; (
  input  logic                    clk,
  input  logic [LLK_SP_IDX_W-1:0] rd_idx,
  output logic [LLK_SP_W-1:0]     rd_lo,
  output logic [LLK_SP_W-1:0]     rd_hi
);

  localparam int          ENTRIES  = 2050;
  localparam int          HALF     = 1024;
  localparam int          TAB_BITS = ENTRIES * LLK_SP_W;
  localparam logic [63:0] ONE_Q60  = 64'd1 << 60;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // ln(1+t) in Q.60 through 2*atanh(t/(2+t)).
  function automatic logic [63:0] ln1p_q60(input logic [63:0] t);
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] y2;
    logic [63:0] pw;
    logic [63:0] acc;
    int          b;
    int          odd;
    den = (ONE_Q60 << 1) + t;
    rem = t;
    quo = '0;
    for (b = 0; b < 60; b++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    y2  = mul_q60(quo, quo);
    pw  = quo;
    acc = '0;
    odd = 1;
    while (odd < 200 && pw != 64'd0) begin
      acc = acc + pw / 64'(odd);
      pw  = mul_q60(pw, y2);
      odd = odd + 2;
    end
    return acc << 1;
  endfunction

  function automatic logic [TAB_BITS-1:0] build_tab();
    logic [63:0]          step;
    logic [63:0]          term;
    logic [63:0]          pw;
    logic [63:0]          lv;
    logic [LLK_SP_W-1:0]  q;
    logic [TAB_BITS-1:0]  tab;
    int                   m;
    int                   d;
    step = ONE_Q60;
    term = ONE_Q60;
    pw   = ONE_Q60;
    m    = 1;
    // Series for exp(-1/64), the ratio between neighboring exponentials.
    while (m <= 40 && term != 64'd0) begin
      term = term / 64'd64 / 64'(m);
      if ((m & 1) == 1) begin
        step = step - term;
      end else begin
        step = step + term;
      end
      m = m + 1;
    end
    tab = '0;
    for (d = 0; d <= HALF; d++) begin
      lv = ln1p_q60(pw);
      q  = LLK_SP_W'((lv + (64'd1 << 43)) >> 44);
      tab[(HALF - d) * LLK_SP_W +: LLK_SP_W] = q;
      tab[(HALF + d) * LLK_SP_W +: LLK_SP_W] = q + LLK_SP_W'(d * HALF);
      pw = mul_q60(pw, step);
    end
    // The entry past the top repeats it, so interpolation at the top is flat.
    tab[(ENTRIES - 1) * LLK_SP_W +: LLK_SP_W] = tab[(ENTRIES - 2) * LLK_SP_W +: LLK_SP_W];
    return tab;
  endfunction

  localparam logic [TAB_BITS-1:0] TAB = build_tab();

  logic [LLK_SP_IDX_W-1:0] idx_hi;

  assign idx_hi = rd_idx + LLK_SP_IDX_W'(1);

  always_ff @(posedge clk) begin
    rd_lo <= TAB[32'(rd_idx) * LLK_SP_W +: LLK_SP_W];
    rd_hi <= TAB[32'(idx_hi) * LLK_SP_W +: LLK_SP_W];
  end

endmodule

// ----- hdl/llk_softplus.sv -----
// Three-stage pipeline that turns a finished dot product into -softplus(u) in Q.16.
module llk_softplus import llk_pkg::*; #(
  parameter int ACC_W = 38
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  llk_obs_ctl_t            z_ctl,
  input  logic signed [ACC_W-1:0] z,
  output llk_ll_t                 ll_o
);

  localparam int FRAC_W   = 18;
  localparam int LIN_SH   = 8;
  localparam int DIFF_W   = LLK_SP_W + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam logic signed [ACC_W-1:0]  LIM      = ACC_W'(1 <<< 28);
  localparam logic signed [ACC_W-1:0]  LIN_RND  = ACC_W'(1 <<< (LIN_SH - 1));
  localparam logic signed [PROD_W-1:0] FRAC_RND = PROD_W'(1 <<< (FRAC_W - 1));

  typedef enum logic [1:0] {
    SP_ZERO,
    SP_LIN,
    SP_TAB
  } sp_cls_t;

  logic signed [ACC_W-1:0]  u;
  logic signed [ACC_W-1:0]  u_lin;
  logic signed [ACC_W-1:0]  u_off;
  sp_cls_t                  cls;
  logic [LLK_SP_IDX_W-1:0]  rom_idx;
  logic [LLK_SP_W-1:0]      rom_lo;
  logic [LLK_SP_W-1:0]      rom_hi;

  logic                     a_valid_r;
  logic                     a_first_r;
  sp_cls_t                  a_cls_r;
  logic [LLK_LL_W-1:0]      a_big_r;
  logic [FRAC_W-1:0]        a_frac_r;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     b_valid_r;
  logic                     b_first_r;
  sp_cls_t                  b_cls_r;
  logic [LLK_LL_W-1:0]      b_big_r;
  logic [LLK_SP_W-1:0]      b_lo_r;
  logic signed [PROD_W-1:0] b_prod_r;

  logic signed [PROD_W-1:0] interp;
  logic [LLK_LL_W-1:0]      sp;

  always_comb begin
    u     = z_ctl.label ? -z : z;
    u_lin = (u + LIN_RND) >>> LIN_SH;
    u_off = u + LIM;
    if (u < -LIM) begin
      cls = SP_ZERO;
    end else if (u > LIM) begin
      cls = SP_LIN;
    end else begin
      cls = SP_TAB;
    end
    rom_idx = (cls == SP_TAB) ? u_off[FRAC_W +: LLK_SP_IDX_W] : '0;
  end

  llk_sp_rom u_rom (
    .clk    (clk),
    .rd_idx (rom_idx),
    .rd_lo  (rom_lo),
    .rd_hi  (rom_hi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= z_ctl.valid;
    end
    a_first_r <= z_ctl.first_obs;
    a_cls_r   <= cls;
    a_big_r   <= (u_lin > LIM) ? LLK_LL_W'(LIM) : u_lin[LLK_LL_W-1:0];
    a_frac_r  <= u_off[FRAC_W-1:0];
  end

  assign diff     = DIFF_W'({1'b0, rom_hi}) - DIFF_W'({1'b0, rom_lo});
  assign prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, a_frac_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_first_r <= a_first_r;
    b_cls_r   <= a_cls_r;
    b_big_r   <= a_big_r;
    b_lo_r    <= rom_lo;
    b_prod_r  <= prod_nxt;
  end

  always_comb begin
    interp = (b_prod_r + FRAC_RND) >>> FRAC_W;
    case (b_cls_r)
      SP_ZERO: sp = '0;
      SP_LIN:  sp = b_big_r;
      SP_TAB:  sp = LLK_LL_W'(b_lo_r) + interp[LLK_LL_W-1:0];
      default: sp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ll_o.valid <= 1'b0;
    end else begin
      ll_o.valid <= b_valid_r;
    end
    ll_o.first_obs <= b_first_r;
    ll_o.ll        <= -$signed(sp);
  end

endmodule

// ----- hdl/llk_out_fifo.sv -----
// Result queue between the pipeline and the output channel.
module llk_out_fifo #(
  parameter int WIDTH = 77,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hdl/logistic_log_likelihood.sv -----
// Top level of the logistic-regression log-likelihood block.
//
// Input items arrive on in_valid/in_stall. A coefficient item writes one Q4.12
// coefficient into the coefficient RAM; a feature item is multiplied by the
// coefficient at the running feature position and summed. The last feature of
// an observation (feature_count features, set through cfg_valid/cfg_ready)
// yields one result item on out_valid/out_stall: -softplus of the signed dot
// product in Q.16, and the running total, cleared first when first_obs is set.
// Throughput is one item per cycle for both kinds while in_stall is low. After
// the last feature the result passes RAM read, multiply, accumulate, table
// lookup, interpolation multiply, negate and total update, each registered. An
// 8-entry result queue absorbs out_stall; in_stall rises once 8 results are
// outstanding. Reset sets feature_count to 1 and clears position, accumulator
// and running total. The coefficient RAM is not cleared: every coefficient an
// observation uses must be written first. cfg_ready is always high; the user
// writes configuration only while no item is in flight (block does not check).
module logistic_log_likelihood import llk_pkg::*; #(
  parameter int MAX_FEATURES = LLK_MAX_FEATURES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  llk_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output llk_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LLK_CFG_W-1:0] cfg_data
);

  localparam int AW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int ACC_W = 2 * LLK_VAL_W + AW;
  localparam int PCW   = (AW + 1 > LLK_CFG_W) ? AW + 1 : LLK_CFG_W;
  localparam int XW    = (AW > LLK_IDX_W) ? AW + 1 : LLK_IDX_W + 1;
  localparam int RW    = $clog2(LLK_OUT_DEPTH + 1);
  localparam int OUT_W = $bits(llk_out_t);
  localparam logic signed [LLK_TOT_W:0] TOT_MIN = -((LLK_TOT_W + 1)'(1) <<< (LLK_TOT_W - 1));

  logic                         in_acc;
  logic                         feat_acc;
  logic                         final_acc;
  logic                         last_feat;
  logic                         coef_wr;
  logic [XW-1:0]                idx_ext;
  logic [PCW-1:0]               pos_inc;

  logic [LLK_CFG_W-1:0]         fc_r;
  logic [AW-1:0]                pos_r;
  logic [RW-1:0]                res_cnt_r;
  logic                         out_pop;

  logic [LLK_VAL_W-1:0]         coef_rdata;
  logic                         s1_valid_r;
  logic                         s1_last_r;
  logic                         s1_label_r;
  logic                         s1_first_r;
  logic signed [LLK_VAL_W-1:0]  s1_value_r;

  logic signed [2*LLK_VAL_W-1:0] prod_nxt;
  logic signed [2*LLK_VAL_W-1:0] prod_r;
  logic                          s2_valid_r;
  logic                          s2_last_r;
  logic                          s2_label_r;
  logic                          s2_first_r;

  logic signed [ACC_W-1:0]      acc_r;
  logic signed [ACC_W-1:0]      acc_sum;
  logic signed [ACC_W-1:0]      z_r;
  llk_obs_ctl_t                 z_ctl_r;

  llk_ll_t                      ll;
  logic signed [LLK_TOT_W-1:0]  total_r;
  logic signed [LLK_TOT_W-1:0]  total_nxt;
  logic signed [LLK_TOT_W-1:0]  tot_base;
  logic signed [LLK_TOT_W:0]    tot_sum;
  llk_out_t                     res_word;
  logic [OUT_W-1:0]             fifo_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (res_cnt_r == RW'(LLK_OUT_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign feat_acc  = in_acc && (in_data.kind == LLK_KIND_FEAT);
  assign idx_ext   = XW'(in_data.coeff_index);
  assign coef_wr   = in_acc && (in_data.kind == LLK_KIND_COEF)
                     && (idx_ext < XW'(MAX_FEATURES));

  // A count of zero behaves as one, a count above the store depth as the depth.
  assign pos_inc   = PCW'(pos_r) + PCW'(1);
  assign last_feat = (pos_inc >= PCW'(fc_r)) || (pos_inc >= PCW'(MAX_FEATURES));
  assign final_acc = feat_acc && last_feat;
  assign out_pop   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r      <= LLK_CFG_W'(1);
      pos_r     <= '0;
      res_cnt_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fc_r <= cfg_data;
      end
      if (feat_acc) begin
        pos_r <= last_feat ? '0 : pos_inc[AW-1:0];
      end
      if (final_acc && !out_pop) begin
        res_cnt_r <= res_cnt_r + RW'(1);
      end else if (out_pop && !final_acc) begin
        res_cnt_r <= res_cnt_r - RW'(1);
      end
    end
  end

  llk_ram #(
    .WIDTH (LLK_VAL_W),
    .DEPTH (MAX_FEATURES)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_wr),
    .waddr (idx_ext[AW-1:0]),
    .wdata (in_data.value),
    .re    (feat_acc),
    .raddr (pos_r),
    .rdata (coef_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= feat_acc;
      s2_valid_r <= s1_valid_r;
    end
    s1_last_r  <= last_feat;
    s1_label_r <= in_data.label;
    s1_first_r <= in_data.first_obs;
    s1_value_r <= in_data.value;
    s2_last_r  <= s1_last_r;
    s2_label_r <= s1_label_r;
    s2_first_r <= s1_first_r;
    prod_r     <= prod_nxt;
  end

  assign prod_nxt = s1_value_r * $signed(coef_rdata);
  assign acc_sum  = acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      z_ctl_r.valid <= 1'b0;
    end else begin
      z_ctl_r.valid <= s2_valid_r && s2_last_r;
      if (s2_valid_r) begin
        acc_r <= s2_last_r ? '0 : acc_sum;
      end
    end
    z_r               <= acc_sum;
    z_ctl_r.label     <= s2_label_r;
    z_ctl_r.first_obs <= s2_first_r;
  end

  llk_softplus #(
    .ACC_W (ACC_W)
  ) u_softplus (
    .clk   (clk),
    .rst_n (rst_n),
    .z_ctl (z_ctl_r),
    .z     (z_r),
    .ll_o  (ll)
  );

  always_comb begin
    tot_base  = ll.first_obs ? '0 : total_r;
    tot_sum   = (LLK_TOT_W + 1)'(tot_base) + (LLK_TOT_W + 1)'(ll.ll);
    total_nxt = (tot_sum < TOT_MIN) ? TOT_MIN[LLK_TOT_W-1:0] : tot_sum[LLK_TOT_W-1:0];
    res_word.obs_loglik   = ll.ll;
    res_word.total_loglik = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ll.valid) begin
      total_r <= total_nxt;
    end
  end

  llk_out_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (LLK_OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ll.valid),
    .wdata     (res_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rdata     (fifo_rdata)
  );

  assign out_data = llk_out_t'(fifo_rdata);

  // Every queued result was reserved when its last feature was taken.
  a_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> res_cnt_r != '0)
    else $error("result queued without a reservation");

  // Log-likelihoods and their running sum are never positive.
  a_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.obs_loglik <= 0 && out_data.total_loglik <= 0))
    else $error("positive log-likelihood on the output");

  // Taking the last feature of an observation restarts the position.
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    final_acc |=> pos_r == '0)
    else $error("feature position not restarted after final feature");

endmodule
